// ===== design/i2a_pkg.sv =====
// Package for the integer to ASCII formatter: sizes, mode codes, item type,
// back-end states and ASCII constants. No dependencies.
package i2a_pkg;

    // Value width and derived digit storage (octal digit count bounds decimal too)
    localparam int VALUE_BITS = 64;
    localparam int NUM_W      = 64;
    localparam int FUNC_W     = 3;
    localparam int WIDTH_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int NDIG       = (VALUE_BITS + 2) / 3;
    localparam int DIG4_W     = NDIG * 4;
    localparam int DIG3_W     = NDIG * 3;
    localparam int CNT_W      = 6;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

    // Queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SDEC = 3'd0,
        FUNC_UDEC = 3'd1,
        FUNC_OCT  = 3'd2,
        FUNC_HEXL = 3'd3,
        FUNC_HEXU = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    // Classified item as it travels from front to back
    typedef struct packed {
        t_radix                  radix;
        logic                    upper;
        logic                    neg;
        logic                    lead;          // '-' goes ahead of pad zeros
        logic [VALUE_BITS-1:0]   mag;
        logic [WIDTH_W-1:0]      width;         // already reduced by a leading '-'
        logic                    zero_pad;
        logic                    left_justify;
    } t_item;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_SIZE,
        B_EMIT
    } t_bstate;

    // One digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base_ch;
        base_ch = upper ? CH_UA : CH_LA;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {3'b000, d};
        end else begin
            digit_char = base_ch + {3'b000, d} - 7'd10;
        end
    endfunction

endpackage

// ===== design/i2a_front.sv =====
// Front end: accepts input beats, drops undefined modes, works out sign,
// magnitude and leading-sign handling. Depends on i2a_pkg.
module i2a_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [i2a_pkg::FUNC_W-1:0]  i_func,
    input  logic [i2a_pkg::NUM_W-1:0]   i_number_bits,
    input  logic [i2a_pkg::WIDTH_W-1:0] i_min_width,
    input  logic                        i_zero_pad,
    input  logic                        i_left_justify,
    input  logic                        i_full,
    output logic                        o_push,
    output i2a_pkg::t_item              o_item
);
    import i2a_pkg::*;

    logic                  known;
    logic                  neg;
    logic                  lead;
    logic [VALUE_BITS-1:0] v;
    t_radix                radix;
    logic                  upper;

    // Mode decode
    always_comb begin
        known = 1'b1;
        radix = RADIX_DEC;
        upper = 1'b0;
        case (t_func'(i_func))
            FUNC_SDEC: radix = RADIX_DEC;
            FUNC_UDEC: radix = RADIX_DEC;
            FUNC_OCT:  radix = RADIX_OCT;
            FUNC_HEXL: radix = RADIX_HEX;
            FUNC_HEXU: begin
                radix = RADIX_HEX;
                upper = 1'b1;
            end
            default:   known = 1'b0;
        endcase
    end

    // Sign and magnitude
    assign v    = i_number_bits[VALUE_BITS-1:0];
    assign neg  = (t_func'(i_func) == FUNC_SDEC) && v[VALUE_BITS-1];
    assign lead = neg && (i_min_width != '0) && i_zero_pad;

    always_comb begin
        o_item.radix        = radix;
        o_item.upper        = upper;
        o_item.neg          = neg;
        o_item.lead         = lead;
        o_item.mag          = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
        o_item.width        = i_min_width - {{(WIDTH_W-1){1'b0}}, lead};
        o_item.zero_pad     = i_zero_pad;
        o_item.left_justify = i_left_justify;
    end

    // Undefined modes are taken and dropped
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && known;

endmodule

// ===== design/i2a_queue.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on i2a_pkg.
module i2a_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2a_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output i2a_pkg::t_item o_item,
    input  logic           i_pop
);
    import i2a_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Pointer and count update
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/i2a_back.sv =====
// Back end: digit extraction (shift-add-3 for decimal, bit slices for octal
// and hex), digit count, then one character per beat. Depends on i2a_pkg.
module i2a_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  i2a_pkg::t_item             i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [i2a_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_last_char
);
    import i2a_pkg::*;

    t_bstate               r_state, n_state;
    t_item                 r_item,  n_item;
    logic [VALUE_BITS-1:0] r_mag,   n_mag;
    logic [DIG4_W-1:0]     r_dig,   n_dig;
    logic [BIT_CNT_W-1:0]  r_bit_cnt, n_bit_cnt;
    logic [CNT_W-1:0]      r_n,     n_n;
    logic [CNT_W-1:0]      r_pad,   n_pad;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [CNT_W-1:0]      r_pos,   n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]     r_out_char,  n_out_char;
    logic                  r_out_last,  n_out_last;

    logic                  out_free;
    logic                  emit_fire;
    logic                  emit_last;
    logic [DIG4_W-1:0]     ext4;
    logic [DIG3_W-1:0]     ext3;
    logic [DIG4_W-1:0]     oct_dig;
    logic [DIG4_W-1:0]     dd_adj;
    logic [CNT_W-1:0]      cnt_calc;
    logic [CNT_W-1:0]      slen;
    logic                  sign_in;
    logic [CHAR_W-1:0]     pad_ch;
    logic [CHAR_W-1:0]     cur_char;
    logic [CNT_W-1:0]      q, q2, q3, didx;
    logic [3:0]            dsel;

    assign out_free  = !r_out_valid || i_ready;
    assign emit_fire = (r_state == B_EMIT) && out_free;
    assign emit_last = (r_pos == r_total - 1'b1);
    assign sign_in   = r_item.neg && !r_item.lead;
    assign pad_ch    = r_item.zero_pad ? CH_ZERO : CH_SPACE;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    n_state = (i_item.radix == RADIX_DEC) ? B_CONV : B_SIZE;
                end
            end
            B_CONV: begin
                if (r_bit_cnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
                    n_state = B_SIZE;
                end
            end
            B_SIZE: n_state = B_EMIT;
            B_EMIT: begin
                if (emit_fire && emit_last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Octal and hex digits straight from the magnitude
    assign ext4 = DIG4_W'(i_item.mag);
    assign ext3 = DIG3_W'(i_item.mag);
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            oct_dig[4*i +: 4] = {1'b0, ext3[3*i +: 3]};
        end
    end

    // Shift-add-3 correction on every BCD digit
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            dd_adj[4*i +: 4] = (r_dig[4*i +: 4] >= 4'd5) ? r_dig[4*i +: 4] + 4'd3
                                                         : r_dig[4*i +: 4];
        end
    end

    // Digit count: highest nonzero digit, at least one
    always_comb begin
        cnt_calc = CNT_W'(1);
        for (int i = 1; i < NDIG; i++) begin
            if (r_dig[4*i +: 4] != 4'd0) begin
                cnt_calc = CNT_W'(i + 1);
            end
        end
    end
    assign slen = cnt_calc + {{(CNT_W-1){1'b0}}, sign_in};

    // Character at the current position
    always_comb begin
        q    = r_pos - {{(CNT_W-1){1'b0}}, r_item.lead};
        q2   = r_item.left_justify ? q : q - r_pad;
        q3   = q2 - {{(CNT_W-1){1'b0}}, sign_in};
        didx = r_n - 1'b1 - q3;
        dsel = 4'd0;
        for (int i = 0; i < NDIG; i++) begin
            if (didx == CNT_W'(i)) begin
                dsel = r_dig[4*i +: 4];
            end
        end
        if (r_item.lead && (r_pos == '0)) begin
            cur_char = CH_MINUS;
        end else if (!r_item.left_justify && (q < r_pad)) begin
            cur_char = pad_ch;
        end else if (sign_in && (q2 == '0)) begin
            cur_char = CH_MINUS;
        end else if (q3 < r_n) begin
            cur_char = digit_char(dsel, r_item.upper);
        end else begin
            cur_char = pad_ch;
        end
    end

    // Datapath and output register
    always_comb begin
        n_item      = r_item;
        n_mag       = r_mag;
        n_dig       = r_dig;
        n_bit_cnt   = r_bit_cnt;
        n_n         = r_n;
        n_pad       = r_pad;
        n_total     = r_total;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        if (i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_item    = i_item;
                    n_mag     = i_item.mag;
                    n_bit_cnt = '0;
                    case (i_item.radix)
                        RADIX_DEC: n_dig = '0;
                        RADIX_OCT: n_dig = oct_dig;
                        RADIX_HEX: n_dig = ext4;
                        default:   n_dig = '0;
                    endcase
                end
            end
            B_CONV: begin
                n_dig     = {dd_adj[DIG4_W-2:0], r_mag[VALUE_BITS-1]};
                n_mag     = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + 1'b1;
            end
            B_SIZE: begin
                n_n     = cnt_calc;
                n_pad   = (r_item.width > slen) ? r_item.width - slen : '0;
                n_total = ((r_item.width > slen) ? r_item.width : slen)
                          + {{(CNT_W-1){1'b0}}, r_item.lead};
                n_pos   = '0;
            end
            B_EMIT: begin
                if (emit_fire) begin
                    n_out_valid = 1'b1;
                    n_out_char  = cur_char;
                    n_out_last  = emit_last;
                    n_pos       = r_pos + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_mag      <= n_mag;
        r_dig      <= n_dig;
        r_bit_cnt  <= n_bit_cnt;
        r_n        <= n_n;
        r_pad      <= n_pad;
        r_total    <= n_total;
        r_pos      <= n_pos;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

endmodule

// ===== design/integer_to_ascii_formatter_top.sv =====
// Integer to ASCII formatter, top level. An accepted item is registered into
// the queue; the back end pops it in B_IDLE, runs the one-bit-per-cycle BCD
// conversion in B_CONV for decimal (octal and hex skip it), sizes digits and
// padding in B_SIZE, then streams one character per cycle in B_EMIT while the
// sink is ready; it pops a new item only after the last character. Synchronous
// active-low reset empties the queue and output register; no clearing pass.
module integer_to_ascii_formatter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [i2a_pkg::FUNC_W-1:0]  i_func,
    input  logic [i2a_pkg::NUM_W-1:0]   i_number_bits,
    input  logic [i2a_pkg::WIDTH_W-1:0] i_min_width,
    input  logic                        i_zero_pad,
    input  logic                        i_left_justify,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [i2a_pkg::CHAR_W-1:0]  o_out_char,
    output logic                        o_last_char
);
    import i2a_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;
    t_item front_item;
    t_item q_item;

    // Classify incoming beats
    i2a_front u_front (
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_number_bits  (i_number_bits),
        .i_min_width    (i_min_width),
        .i_zero_pad     (i_zero_pad),
        .i_left_justify (i_left_justify),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_item         (front_item)
    );

    // Decouple front from back
    i2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Convert and stream characters
    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

// ===== test/tb_integer_to_ascii_formatter_top.sv =====
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_formatter_top: directed and random numbers in all modes,
// every character checked against a formatter written here. Depends on i2a_pkg and the top.
module tb_integer_to_ascii_formatter_top;
    import i2a_pkg::*;

    localparam int          RESET_CYCLES   = 6;
    localparam int unsigned RANDOM_NUMBERS = 230;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 200;
    localparam int unsigned HOLD_AT        = 60;
    localparam int unsigned DRAIN_AT       = 150;

    // Mode codes the block must drop without output
    localparam logic [FUNC_W-1:0] FUNC_BAD_FIRST = FUNC_W'(FUNC_HEXU + 1);
    localparam logic [FUNC_W-1:0] FUNC_BAD_LAST  = '1;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_fmt_char;

    // Formats each accepted number and checks the characters that come back
    class format_scoreboard;
        t_fmt_char   pending_chars[$];
        int unsigned mismatches;
        int unsigned chars_seen;

        function void note_number(logic [FUNC_W-1:0] f, logic [NUM_W-1:0] raw,
                                  logic [WIDTH_W-1:0] w, logic zp, logic lj);
            logic [NUM_W-1:0]  mag;
            logic [CHAR_W-1:0] digs[$];
            logic [CHAR_W-1:0] line[$];
            logic [CHAR_W-1:0] letter;
            logic [CHAR_W-1:0] padch;
            logic [3:0]        d;
            logic              neg;
            logic              lead;
            int unsigned       radix;
            int unsigned       width;
            int unsigned       slen;
            int unsigned       pad;
            // undefined modes produce nothing
            if (f > FUNC_HEXU) return;
            radix  = (f == FUNC_SDEC || f == FUNC_UDEC) ? 10 : ((f == FUNC_OCT) ? 8 : 16);
            letter = (f == FUNC_HEXU) ? CH_UA : CH_LA;
            neg    = (f == FUNC_SDEC) && raw[NUM_W-1];
            mag    = neg ? -raw : raw;
            width  = w;

            // digits, most significant first
            if (mag == 0) digs.push_front(CH_ZERO);
            while (mag != 0) begin
                d = 4'(mag % radix);
                digs.push_front((d < 4'd10) ? CH_ZERO + 7'(d) : letter + 7'(d) - 7'd10);
                mag = mag / radix;
            end

            // sign goes ahead of pad zeros only when zero padding a nonzero width
            lead = neg && (width != 0) && zp;
            if (lead) begin
                line.push_back(CH_MINUS);
                width--;
            end
            slen  = digs.size() + ((neg && !lead) ? 1 : 0);
            pad   = (width > slen) ? width - slen : 0;
            padch = zp ? CH_ZERO : CH_SPACE;
            if (!lj) repeat (pad) line.push_back(padch);
            if (neg && !lead) line.push_back(CH_MINUS);
            foreach (digs[i]) line.push_back(digs[i]);
            if (lj) repeat (pad) line.push_back(padch);

            foreach (line[i]) pending_chars.push_back('{ch: line[i], last: (i == line.size() - 1)});
        endfunction

        task report(string msg);
            $display("MISMATCH at char %0d: %s", chars_seen, msg);
            mismatches++;
        endtask

        task check_char(logic [CHAR_W-1:0] ch, logic last);
            t_fmt_char want;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch)
                report($sformatf("out_char 0x%02h, want 0x%02h", ch, want.ch));
            if (last !== want.last)
                report($sformatf("last_char %0b, want %0b", last, want.last));
        endtask

        function int unsigned outstanding();
            return pending_chars.size();
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func         = '0;
    logic [NUM_W-1:0]    i_number_bits  = '0;
    logic [WIDTH_W-1:0]  i_min_width    = '0;
    logic                i_zero_pad     = 1'b0;
    logic                i_left_justify = 1'b0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [CHAR_W-1:0]   o_out_char;
    logic                o_last_char;

    format_scoreboard fmt_sb = new();
    bit               tx_idle    = 1'b1;
    int unsigned      burst_left = 0;
    bit               hold_rx    = 1'b0;

    integer_to_ascii_formatter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_number_bits  (i_number_bits),
        .i_min_width    (i_min_width),
        .i_zero_pad     (i_zero_pad),
        .i_left_justify (i_left_justify),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

    always #5 i_clk = ~i_clk;

    // Offer one number; called at a falling edge, returns at the falling edge after its beat
    task automatic send_number(input logic [FUNC_W-1:0] f, input logic [NUM_W-1:0] n,
                               input logic [WIDTH_W-1:0] w, input logic zp, input logic lj);
        int unsigned gap;
        gap = (tx_idle && burst_left == 0) ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= f;
        i_number_bits  <= n;
        i_min_width    <= w;
        i_zero_pad     <= zp;
        i_left_justify <= lj;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        fmt_sb.note_number(f, n, w, zp, lj);
        @(negedge i_clk);
    endtask

    // Wait at falling edges until every expected character is back
    task automatic wait_drained();
        while (fmt_sb.outstanding() != 0) @(negedge i_clk);
    endtask

    // Stimulus
    initial begin : stimulus
        int unsigned        sent;
        bit                 hold_asked;
        bit                 drain_done;
        logic [FUNC_W-1:0]  f;
        logic [NUM_W-1:0]   value;
        logic [WIDTH_W-1:0] w;
        sent       = 0;
        hold_asked = 1'b0;
        drain_done = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero, extremes, sign placement, padding, width overflow, bad modes
        send_number(FUNC_SDEC, 64'd0, 6'd0, 1'b0, 1'b0);
        send_number(FUNC_SDEC, 64'h8000_0000_0000_0000, 6'd0, 1'b0, 1'b0);
        send_number(FUNC_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd25, 1'b0, 1'b0);
        send_number(FUNC_SDEC, -64'd1, 6'd5, 1'b1, 1'b0);
        send_number(FUNC_SDEC, -64'd42, 6'd6, 1'b0, 1'b0);
        send_number(FUNC_SDEC, -64'd42, 6'd6, 1'b1, 1'b1);
        send_number(FUNC_SDEC, -64'd42, 6'd6, 1'b0, 1'b1);
        send_number(FUNC_SDEC, -64'd7, 6'd1, 1'b1, 1'b0);
        send_number(FUNC_SDEC, -64'd7, 6'd0, 1'b1, 1'b0);
        send_number(FUNC_UDEC, '1, 6'd63, 1'b0, 1'b0);
        send_number(FUNC_UDEC, 64'd0, 6'd63, 1'b1, 1'b1);
        send_number(FUNC_UDEC, 64'h8000_0000_0000_0000, 6'd0, 1'b0, 1'b0);
        send_number(FUNC_UDEC, 64'd123456, 6'd3, 1'b1, 1'b0);
        send_number(FUNC_OCT, '1, 6'd63, 1'b0, 1'b1);
        send_number(FUNC_OCT, 64'd8, 6'd4, 1'b1, 1'b0);
        send_number(FUNC_HEXL, 64'hDEAD_BEEF_CAFE_F00D, 6'd0, 1'b0, 1'b0);
        send_number(FUNC_HEXU, 64'hFEDC_BA98_7654_3210, 6'd20, 1'b1, 1'b0);
        send_number(FUNC_HEXL, '1, 6'd16, 1'b0, 1'b0);
        send_number(FUNC_HEXU, 64'd0, 6'd63, 1'b0, 1'b1);
        send_number(FUNC_HEXU, 64'h0000_0000_0000_ABCD, 6'd2, 1'b0, 1'b0);
        send_number(FUNC_BAD_FIRST, 64'd12345, 6'd10, 1'b0, 1'b0);
        send_number(FUNC_W'(FUNC_BAD_FIRST + 1), '1, 6'd63, 1'b1, 1'b1);
        send_number(FUNC_BAD_LAST, 64'd0, 6'd0, 1'b0, 1'b0);

        // random numbers; ignored modes do not count
        while (sent < RANDOM_NUMBERS) begin
            tx_idle = ((sent / 20) % 3) != 2;
            if (sent == HOLD_AT && !hold_asked) begin
                // sink stalls for a long stretch while back-to-back beats fill the block
                hold_asked = 1'b1;
                hold_rx    = 1'b1;
                burst_left = 16;
            end
            if (sent == DRAIN_AT && !drain_done) begin
                drain_done = 1'b1;
                i_valid <= 1'b0;
                wait_drained();
            end
            f = ($urandom_range(0, 15) == 0)
                ? FUNC_W'($urandom_range(FUNC_BAD_FIRST, FUNC_BAD_LAST))
                : FUNC_W'($urandom_range(FUNC_SDEC, FUNC_HEXU));
            case ($urandom_range(0, 5))
                0: value = {$urandom, $urandom};
                1: value = 64'($urandom_range(0, 1000));
                2: value = -64'($urandom_range(1, 100000));
                3: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
                4: value = {$urandom, $urandom} >> $urandom_range(0, 63);
                default: value = {1'b1, 63'($urandom_range(0, 3))};
            endcase
            w = ($urandom_range(0, 3) == 0) ? WIDTH_W'($urandom_range(0, 63))
                                           : WIDTH_W'($urandom_range(0, 24));
            send_number(f, value, w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (f <= FUNC_HEXU) sent++;
            if (burst_left != 0) burst_left--;
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fmt_sb.mismatches == 0 && fmt_sb.outstanding() == 0)
            $display("tb_integer_to_ascii_formatter_top passed");
        else
            $display("tb_integer_to_ascii_formatter_top failed");
        $finish;
    end

    // Character sink with random stalls and one long hold-off
    initial begin : sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_rx) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            stall = (((taken / 50) % 3) != 1) ? $urandom_range(0, 11) : 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            fmt_sb.check_char(o_out_char, o_last_char);
            taken++;
            @(negedge i_clk);
        end
    end

    // Watchdog: too long without any beat on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_integer_to_ascii_formatter_top failed");
        $finish;
    end

endmodule
